// File: hw/rtl/glh_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Gaussian landmark heatmap package
// Shared constants, word types and the exponential lookup table.
// ----------------------------------------------------------------------------
package glh_pkg;

    // Block limits
    localparam int MAX_ROI      = 3;
    localparam int MAX_MAP_SIZE = 1024;
    localparam int EXP_DEPTH    = 256;

    // Field and datapath widths
    localparam int CFG_W     = 12;
    localparam int CFG_IDX_W = 2;
    localparam int DIM_W     = 11;
    localparam int ROI_W     = 2;
    localparam int SIG_W     = 12;
    localparam int LM_W      = 17;
    localparam int POS_W     = 27;
    localparam int CTR_W     = 12;
    localparam int CELL_W    = 12;
    localparam int PROB_W    = 17;
    localparam int DEN_W     = 25;
    localparam int EXP_IDX_W = $clog2(EXP_DEPTH);
    localparam int EXP_SH    = 20 - EXP_IDX_W;
    localparam int OFF_W     = 20;
    localparam int SQ_W      = 36;
    localparam int DSR_W     = DEN_W + EXP_SH;
    localparam int NUM_W     = DSR_W + 1;
    localparam int DIV_Q     = 17;
    localparam int SUM_W     = 22;
    localparam int WIN_W     = 6;
    localparam int WIN_MAX   = (2 * MAX_ROI + 1) * (2 * MAX_ROI + 1);
    localparam int AXIS_W    = 3;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W    = $clog2(QUEUE_DEPTH);

    localparam logic [PROB_W-1:0] PROB_ONE = 17'h10000;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROI_RADIUS = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SIGMA      = 2'd3;

    // Configuration reset values
    localparam logic [DIM_W-1:0] MAP_WIDTH_RST  = 11'd64;
    localparam logic [DIM_W-1:0] MAP_HEIGHT_RST = 11'd64;
    localparam logic [ROI_W-1:0] ROI_RADIUS_RST = 2'd2;
    localparam logic [SIG_W-1:0] SIGMA_RST      = 12'd256;

    typedef struct packed {
        logic [DIM_W-1:0] map_width;
        logic [DIM_W-1:0] map_height;
        logic [ROI_W-1:0] roi_radius;
        logic [SIG_W-1:0] sigma;
    } glh_cfg_t;

    // One landmark word as classified by the front end
    typedef struct packed {
        logic [POS_W-1:0] px;
        logic [POS_W-1:0] py;
        logic [CTR_W-1:0] cx;
        logic [CTR_W-1:0] cy;
        logic [DIM_W-1:0] w;
        logic [DIM_W-1:0] h;
        logic [ROI_W-1:0] r;
        logic [DEN_W-1:0] den;
    } glh_job_t;

    typedef struct packed {
        logic             valid;
        logic             zero;
        logic [NUM_W-1:0] num;
        logic [DSR_W-1:0] dsr;
    } glh_div_req_t;

    typedef struct packed {
        logic             valid;
        logic             zero;
        logic [DIV_Q-1:0] quot;
    } glh_div_rsp_t;

    typedef logic [PROB_W-1:0] exp_tab_t [EXP_DEPTH];

    // Builds exp(-j*16/EXP_DEPTH) in Q1.16 from a series and repeated squaring.
    function automatic exp_tab_t build_exp_tab();
        exp_tab_t    t;
        logic [63:0] y;
        logic [63:0] y2;
        logic [63:0] y3;
        logic [63:0] y4;
        logic [63:0] v;
        for (int j = 0; j < EXP_DEPTH; j++)
        begin
            if (j == 0)
            begin
                t[j] = PROB_ONE;
            end
            else
            begin
                y  = (64'(j) << 36) / 64'(EXP_DEPTH * 256);
                y2 = (y * y) >> 32;
                y3 = (y2 * y) >> 32;
                y4 = (y3 * y) >> 32;
                v  = (64'd1 << 32) - y + y2 / 64'd2 - y3 / 64'd6 + y4 / 64'd24;
                if (v > 64'hFFFF_FFFF)
                begin
                    v = 64'hFFFF_FFFF;
                end
                for (int i = 0; i < 8; i++)
                begin
                    v = (v * v + 64'h8000_0000) >> 32;
                end
                v = (v + 64'd32768) >> 16;
                t[j] = (v > 64'd65536) ? PROB_ONE : v[PROB_W-1:0];
            end
        end
        return t;
    endfunction

    localparam exp_tab_t EXP_TAB = build_exp_tab();

endpackage
`default_nettype wire

// File: hw/rtl/glh_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Gaussian landmark heatmap front end
// Accepts a landmark, scales it by the map size and forms the centre cell and
// the Gaussian denominator, then hands the word to the queue.
// ----------------------------------------------------------------------------
module glh_front import glh_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  logic [LM_W-1:0]  landmark_x,
    input  logic [LM_W-1:0]  landmark_y,
    input  glh_cfg_t         cfg,
    input  logic             q_full,
    output logic             push,
    output glh_job_t         job
);

    logic                 f_valid_reg;
    logic [POS_W-1:0]     px_reg;
    logic [POS_W-1:0]     py_reg;
    logic [2*SIG_W-1:0]   ss_reg;
    logic [DIM_W-1:0]     w_reg;
    logic [DIM_W-1:0]     h_reg;
    logic [ROI_W-1:0]     r_reg;
    logic                 accept;
    logic [DIM_W-1:0]     w_clamp;
    logic [DIM_W-1:0]     h_clamp;
    logic [ROI_W-1:0]     r_clamp;
    logic [SIG_W-1:0]     s_eff;

    // Saturate the register values to what the datapath supports.
    assign w_clamp = (cfg.map_width > DIM_W'(MAX_MAP_SIZE)) ? DIM_W'(MAX_MAP_SIZE)
                                                            : cfg.map_width;
    assign h_clamp = (cfg.map_height > DIM_W'(MAX_MAP_SIZE)) ? DIM_W'(MAX_MAP_SIZE)
                                                             : cfg.map_height;
    assign r_clamp = (cfg.roi_radius > ROI_W'(MAX_ROI)) ? ROI_W'(MAX_ROI) : cfg.roi_radius;
    assign s_eff   = (cfg.sigma == '0) ? SIG_W'(1) : cfg.sigma;

    assign busy   = f_valid_reg;
    assign accept = start && !busy;
    assign push   = f_valid_reg && !q_full;

    // Hold a word in the product stage until the queue takes it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            f_valid_reg <= 1'b1;
        end
        else if (push)
        begin
            f_valid_reg <= 1'b0;
        end
    end

    // Scaled position and sigma squared.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            px_reg <= POS_W'(landmark_x) * POS_W'(w_clamp);
            py_reg <= POS_W'(landmark_y) * POS_W'(h_clamp);
            ss_reg <= (2*SIG_W)'(s_eff) * (2*SIG_W)'(s_eff);
            w_reg  <= w_clamp;
            h_reg  <= h_clamp;
            r_reg  <= r_clamp;
        end
    end

    // Centre cell is the scaled position rounded half up; the sum needs one
    // bit more than the position, as the centre can reach 2048.
    always_comb
    begin
        job.px  = px_reg;
        job.py  = py_reg;
        job.cx  = CTR_W'(({1'b0, px_reg} + (POS_W+1)'(32768)) >> 16);
        job.cy  = CTR_W'(({1'b0, py_reg} + (POS_W+1)'(32768)) >> 16);
        job.w   = w_reg;
        job.h   = h_reg;
        job.r   = r_reg;
        job.den = DEN_W'({ss_reg, 1'b0});
    end

endmodule
`default_nettype wire

// File: hw/rtl/glh_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Gaussian landmark heatmap job queue
// A short first-in first-out buffer that decouples the front and back ends.
// ----------------------------------------------------------------------------
module glh_queue import glh_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  glh_job_t push_job,
    output logic     full,
    input  logic     pop,
    output logic     job_valid,
    output glh_job_t pop_job
);

    glh_job_t           mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QPTR_W:0]    cnt_reg;

    assign full      = (cnt_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign job_valid = (cnt_reg != '0);
    assign pop_job   = mem_reg[rd_ptr_reg];

    // Pointers and fill level.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    // Storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule
`default_nettype wire

// File: hw/rtl/glh_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Gaussian landmark heatmap divider
// Pipelined restoring divider, one quotient bit per stage. The numerator must
// be below the divisor shifted by the quotient width.
// ----------------------------------------------------------------------------
module glh_div import glh_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  glh_div_req_t req,
    output glh_div_rsp_t rsp
);

    logic             v_reg   [DIV_Q];
    logic             z_reg   [DIV_Q];
    logic [DSR_W-1:0] rem_reg [DIV_Q];
    logic [DIV_Q-1:0] lo_reg  [DIV_Q];
    logic [DIV_Q-1:0] q_reg   [DIV_Q];
    logic [DSR_W-1:0] d_reg   [DIV_Q];

    logic [DSR_W-1:0] rem_in  [DIV_Q];
    logic [DIV_Q-1:0] lo_in   [DIV_Q];
    logic [DIV_Q-1:0] q_in    [DIV_Q];
    logic [DSR_W-1:0] d_in    [DIV_Q];
    logic [DSR_W-1:0] rem_out [DIV_Q];
    logic             qbit    [DIV_Q];

    // Stage inputs: the request for the first stage, the previous stage after.
    always_comb
    begin
        rem_in[0] = DSR_W'(req.num >> DIV_Q);
        lo_in[0]  = req.num[DIV_Q-1:0];
        q_in[0]   = '0;
        d_in[0]   = req.dsr;
        for (int i = 1; i < DIV_Q; i++)
        begin
            rem_in[i] = rem_reg[i-1];
            lo_in[i]  = lo_reg[i-1];
            q_in[i]   = q_reg[i-1];
            d_in[i]   = d_reg[i-1];
        end
    end

    // One compare and subtract per stage.
    always_comb
    begin
        for (int i = 0; i < DIV_Q; i++)
        begin
            qbit[i]    = ({rem_in[i], lo_in[i][DIV_Q-1]} >= {1'b0, d_in[i]});
            rem_out[i] = qbit[i] ? DSR_W'({rem_in[i], lo_in[i][DIV_Q-1]} - {1'b0, d_in[i]})
                                 : DSR_W'({rem_in[i], lo_in[i][DIV_Q-1]});
        end
    end

    // Stage valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DIV_Q; i++)
            begin
                v_reg[i] <= 1'b0;
            end
        end
        else
        begin
            v_reg[0] <= req.valid;
            for (int i = 1; i < DIV_Q; i++)
            begin
                v_reg[i] <= v_reg[i-1];
            end
        end
    end

    // Stage payload.
    always_ff @(posedge clk)
    begin
        z_reg[0] <= req.zero;
        for (int i = 1; i < DIV_Q; i++)
        begin
            z_reg[i] <= z_reg[i-1];
        end
        for (int i = 0; i < DIV_Q; i++)
        begin
            rem_reg[i] <= rem_out[i];
            lo_reg[i]  <= {lo_in[i][DIV_Q-2:0], 1'b0};
            q_reg[i]   <= {q_in[i][DIV_Q-2:0], qbit[i]};
            d_reg[i]   <= d_in[i];
        end
    end

    assign rsp.valid = v_reg[DIV_Q-1];
    assign rsp.zero  = z_reg[DIV_Q-1];
    assign rsp.quot  = q_reg[DIV_Q-1];

endmodule
`default_nettype wire

// File: hw/rtl/glh_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Gaussian landmark heatmap back end
// Evaluates the window through the shared divider and the exponential table,
// sums it, then normalises each cell through the divider and emits it.
// ----------------------------------------------------------------------------
module glh_back import glh_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               job_valid,
    input  glh_job_t           job,
    output logic               pop,
    output glh_div_req_t       req,
    input  glh_div_rsp_t       rsp,
    output logic               result_valid,
    output logic [CELL_W-1:0]  cell_x,
    output logic [CELL_W-1:0]  cell_y,
    output logic               inside_map,
    output logic [PROB_W-1:0]  probability,
    output logic               last_cell
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EVAL = 3'b010,
        S_NORM = 3'b100
    } glh_state_t;

    glh_state_t                state_reg;
    glh_job_t                  job_reg;
    logic [WIN_W-1:0]          win_reg;
    logic [AXIS_W-1:0]         ix_reg;
    logic [AXIS_W-1:0]         iy_reg;
    logic                      iss_on_reg;
    logic                      a1_v_reg;
    logic                      a2_v_reg;
    logic                      a3_v_reg;
    logic signed [OFF_W-1:0]   ox_reg;
    logic signed [OFF_W-1:0]   oy_reg;
    logic [SQ_W-1:0]           sqx_reg;
    logic [SQ_W-1:0]           sqy_reg;
    logic [NUM_W-1:0]          num_reg;
    logic                      req_v_reg;
    logic                      req_z_reg;
    logic [NUM_W-1:0]          req_num_reg;
    logic [DSR_W-1:0]          req_dsr_reg;
    logic [WIN_W-1:0]          rcv_reg;
    logic [SUM_W-1:0]          sum_reg;
    logic [PROB_W-1:0]         ev_mem [WIN_MAX];
    logic                      rd_on_reg;
    logic [WIN_W-1:0]          rd_idx_reg;
    logic                      b1_v_reg;
    logic [PROB_W-1:0]         e_rd_reg;
    logic [AXIS_W-1:0]         ex_reg;
    logic [AXIS_W-1:0]         ey_reg;
    logic [WIN_W-1:0]          oc_reg;
    logic                      res_v_reg;
    logic [CELL_W-1:0]         cell_x_reg;
    logic [CELL_W-1:0]         cell_y_reg;
    logic                      inside_reg;
    logic [PROB_W-1:0]         prob_reg;
    logic                      last_reg;

    logic [AXIS_W-1:0]         side_m1;
    logic [WIN_W-1:0]          win_m1;
    logic [12:0]               ix_pos;
    logic [12:0]               iy_pos;
    logic [29:0]               ox_full;
    logic [29:0]               oy_full;
    logic signed [2*OFF_W-1:0] sqx_full;
    logic signed [2*OFF_W-1:0] sqy_full;
    logic [DSR_W-1:0]          dsr_a;
    logic                      zero_a;
    logic [PROB_W-1:0]         e_new;
    logic [12:0]               ex_pos;
    logic [12:0]               ey_pos;
    logic [PROB_W-1:0]         p_sat;

    // Cell coordinate along one axis: centre plus offset minus radius.
    function automatic logic [12:0] axis_pos(logic [CTR_W-1:0] c, logic [AXIS_W-1:0] i,
                                             logic [ROI_W-1:0] r);
        return {1'b0, c} + 13'(i) - 13'(r);
    endfunction

    assign side_m1 = {job_reg.r, 1'b0};
    assign win_m1  = WIN_W'(win_reg - 1'b1);
    assign pop     = (state_reg == S_IDLE) && job_valid;

    // Offsets of the issued cell from the scaled landmark, in Q.16.
    assign ix_pos  = axis_pos(job_reg.cx, ix_reg, job_reg.r);
    assign iy_pos  = axis_pos(job_reg.cy, iy_reg, job_reg.r);
    assign ox_full = {ix_pos[12], ix_pos, 16'b0} - 30'(job_reg.px);
    assign oy_full = {iy_pos[12], iy_pos, 16'b0} - 30'(job_reg.py);
    assign sqx_full = ox_reg * ox_reg;
    assign sqy_full = oy_reg * oy_reg;

    // Table index is rounded d^2 / (2 sigma^2) scaled to the table depth;
    // anything past the last entry reads as zero.
    assign dsr_a  = {job_reg.den, {EXP_SH{1'b0}}};
    assign zero_a = ({{(DSR_W+EXP_IDX_W-NUM_W){1'b0}}, num_reg}
                     >= {dsr_a, {EXP_IDX_W{1'b0}}});
    assign e_new  = rsp.zero ? '0 : EXP_TAB[rsp.quot[EXP_IDX_W-1:0]];

    // Output cell position and saturated probability.
    assign ex_pos = axis_pos(job_reg.cx, ex_reg, job_reg.r);
    assign ey_pos = axis_pos(job_reg.cy, ey_reg, job_reg.r);
    assign p_sat  = rsp.zero ? '0 :
                    ((rsp.quot > PROB_ONE) ? PROB_ONE : rsp.quot);

    // Sequencer and control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            iss_on_reg <= 1'b0;
            ix_reg     <= '0;
            iy_reg     <= '0;
            a1_v_reg   <= 1'b0;
            a2_v_reg   <= 1'b0;
            a3_v_reg   <= 1'b0;
            req_v_reg  <= 1'b0;
            rcv_reg    <= '0;
            sum_reg    <= '0;
            rd_on_reg  <= 1'b0;
            rd_idx_reg <= '0;
            b1_v_reg   <= 1'b0;
            ex_reg     <= '0;
            ey_reg     <= '0;
            oc_reg     <= '0;
            res_v_reg  <= 1'b0;
        end
        else
        begin
            a1_v_reg  <= iss_on_reg;
            a2_v_reg  <= a1_v_reg;
            a3_v_reg  <= a2_v_reg;
            b1_v_reg  <= rd_on_reg;
            req_v_reg <= a3_v_reg | b1_v_reg;
            res_v_reg <= (state_reg == S_NORM) && rsp.valid;
            case (state_reg)
                S_IDLE:
                begin
                    if (job_valid)
                    begin
                        state_reg  <= S_EVAL;
                        iss_on_reg <= 1'b1;
                        ix_reg     <= '0;
                        iy_reg     <= '0;
                        rcv_reg    <= '0;
                        sum_reg    <= '0;
                        ex_reg     <= '0;
                        ey_reg     <= '0;
                        oc_reg     <= '0;
                    end
                end
                S_EVAL:
                begin
                    if (iss_on_reg)
                    begin
                        if (ix_reg == side_m1)
                        begin
                            ix_reg <= '0;
                            if (iy_reg == side_m1)
                            begin
                                iss_on_reg <= 1'b0;
                            end
                            else
                            begin
                                iy_reg <= iy_reg + 1'b1;
                            end
                        end
                        else
                        begin
                            ix_reg <= ix_reg + 1'b1;
                        end
                    end
                    if (rsp.valid)
                    begin
                        sum_reg <= sum_reg + SUM_W'(e_new);
                        rcv_reg <= rcv_reg + 1'b1;
                        if (rcv_reg == win_m1)
                        begin
                            state_reg  <= S_NORM;
                            rd_on_reg  <= 1'b1;
                            rd_idx_reg <= '0;
                        end
                    end
                end
                S_NORM:
                begin
                    if (rd_on_reg)
                    begin
                        if (rd_idx_reg == win_m1)
                        begin
                            rd_on_reg <= 1'b0;
                        end
                        rd_idx_reg <= rd_idx_reg + 1'b1;
                    end
                    if (rsp.valid)
                    begin
                        oc_reg    <= oc_reg + 1'b1;
                        if (ex_reg == side_m1)
                        begin
                            ex_reg <= '0;
                            ey_reg <= ey_reg + 1'b1;
                        end
                        else
                        begin
                            ex_reg <= ex_reg + 1'b1;
                        end
                        if (oc_reg == win_m1)
                        begin
                            state_reg <= S_IDLE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Datapath registers, window store and result word.
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            job_reg <= job;
            win_reg <= WIN_W'({job.r, 1'b1}) * WIN_W'({job.r, 1'b1});
        end
        ox_reg  <= ox_full[OFF_W-1:0];
        oy_reg  <= oy_full[OFF_W-1:0];
        sqx_reg <= sqx_full[SQ_W-1:0];
        sqy_reg <= sqy_full[SQ_W-1:0];
        num_reg <= NUM_W'(sqx_reg) + NUM_W'(sqy_reg)
                   + NUM_W'({job_reg.den, {(EXP_SH-1){1'b0}}});
        if (a3_v_reg)
        begin
            req_z_reg   <= zero_a;
            req_num_reg <= num_reg;
            req_dsr_reg <= dsr_a;
        end
        else
        begin
            req_z_reg   <= (sum_reg == '0);
            req_num_reg <= NUM_W'({e_rd_reg, 16'b0}) + NUM_W'(sum_reg >> 1);
            req_dsr_reg <= DSR_W'(sum_reg);
        end
        if ((state_reg == S_EVAL) && rsp.valid)
        begin
            ev_mem[rcv_reg] <= e_new;
        end
        if (rd_on_reg)
        begin
            e_rd_reg <= ev_mem[rd_idx_reg];
        end
        if ((state_reg == S_NORM) && rsp.valid)
        begin
            cell_x_reg <= ex_pos[CELL_W-1:0];
            cell_y_reg <= ey_pos[CELL_W-1:0];
            inside_reg <= !ex_pos[12] && !ey_pos[12]
                          && (ex_pos[CELL_W-1:0] < {1'b0, job_reg.w})
                          && (ey_pos[CELL_W-1:0] < {1'b0, job_reg.h});
            prob_reg   <= p_sat;
            last_reg   <= (oc_reg == win_m1);
        end
    end

    assign req.valid    = req_v_reg;
    assign req.zero     = req_z_reg;
    assign req.num      = req_num_reg;
    assign req.dsr      = req_dsr_reg;
    assign result_valid = res_v_reg;
    assign cell_x       = cell_x_reg;
    assign cell_y       = cell_y_reg;
    assign inside_map   = inside_reg;
    assign probability  = prob_reg;
    assign last_cell    = last_reg;

`ifndef SYNTHESIS
    // The divider only returns words while a window is being worked on.
    a_rsp_in_job: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> (state_reg == S_EVAL || state_reg == S_NORM))
        else $error("divider word outside a job");

    // No result may be shown while a new window is being evaluated.
    a_no_emit_in_eval: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EVAL) |-> !res_v_reg)
        else $error("result emitted during evaluation");

    // Normalisation starts only once the whole window has been summed.
    a_sum_complete: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_NORM) |-> (rcv_reg == win_reg))
        else $error("normalising an incomplete window");

    // The last cell of a window is never followed directly by another result.
    a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (res_v_reg && last_reg) |=> !res_v_reg)
        else $error("result straight after last cell");
`endif

endmodule
`default_nettype wire

// File: hw/rtl/gaussian_landmark_heatmap.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Gaussian landmark heatmap
// Renders a normalised Gaussian window of (2r+1)^2 cells around one landmark.
// ----------------------------------------------------------------------------
// A landmark is taken when start is high and busy is low; the front end holds
// it until the queue takes it, and a two-word queue lets a second landmark
// wait while the previous window is still being worked on. Every cell of a
// window of n = (2r+1)^2 cells passes twice through one shared 17-stage
// divider pipeline, once to find its table index and once to be normalised
// by the window sum. Results appear one per cycle with result_valid high for
// a single cycle each, in row-major order, and the receiver cannot hold them
// off. Configuration writes must be made while no landmark is in flight.
module gaussian_landmark_heatmap import glh_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 start,
    output logic                 busy,
    input  logic [LM_W-1:0]      landmark_x,
    input  logic [LM_W-1:0]      landmark_y,
    output logic                 result_valid,
    output logic [CELL_W-1:0]    cell_x,
    output logic [CELL_W-1:0]    cell_y,
    output logic                 inside_map,
    output logic [PROB_W-1:0]    probability,
    output logic                 last_cell
);

    glh_cfg_t     cfg_reg;
    logic         q_full;
    logic         push;
    glh_job_t     push_job;
    logic         pop;
    logic         job_valid;
    glh_job_t     pop_job;
    glh_div_req_t div_req;
    glh_div_rsp_t div_rsp;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.map_width  <= MAP_WIDTH_RST;
            cfg_reg.map_height <= MAP_HEIGHT_RST;
            cfg_reg.roi_radius <= ROI_RADIUS_RST;
            cfg_reg.sigma      <= SIGMA_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_MAP_WIDTH:  cfg_reg.map_width  <= cfg_data[DIM_W-1:0];
                CFG_MAP_HEIGHT: cfg_reg.map_height <= cfg_data[DIM_W-1:0];
                CFG_ROI_RADIUS: cfg_reg.roi_radius <= cfg_data[ROI_W-1:0];
                CFG_SIGMA:      cfg_reg.sigma      <= cfg_data[SIG_W-1:0];
                default:        cfg_reg            <= cfg_reg;
            endcase
        end
    end

    glh_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .landmark_x (landmark_x),
        .landmark_y (landmark_y),
        .cfg        (cfg_reg),
        .q_full     (q_full),
        .push       (push),
        .job        (push_job)
    );

    glh_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_job  (push_job),
        .full      (q_full),
        .pop       (pop),
        .job_valid (job_valid),
        .pop_job   (pop_job)
    );

    glh_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    glh_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .job_valid    (job_valid),
        .job          (pop_job),
        .pop          (pop),
        .req          (div_req),
        .rsp          (div_rsp),
        .result_valid (result_valid),
        .cell_x       (cell_x),
        .cell_y       (cell_y),
        .inside_map   (inside_map),
        .probability  (probability),
        .last_cell    (last_cell)
    );

endmodule
`default_nettype wire

// File: tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gaussian landmark heatmap testbench
// Writes a sequence of register settings and sends landmark words. Every
// emitted cell is checked against the directed table or an internal model of
// the window arithmetic. The run starts with a short directed table and
// continues with random phases that differ in how often the sender idles.
// ----------------------------------------------------------------------------
module tb;
    import glh_pkg::*;

    typedef struct packed {
        logic [CELL_W-1:0] cx;
        logic [CELL_W-1:0] cy;
        logic              in_map;
        logic [PROB_W-1:0] prob;
        logic              last;
    } cell_word_t;

    typedef struct {
        int         w;
        int         h;
        int         r;
        int         sig;
        int         lx;
        int         ly;
        bit         typed;
        cell_word_t want;
    } dir_row_t;

    localparam int N_DIR = 14;
    localparam int DRAIN = 200;

    logic              clk;
    logic              rst_n;
    logic              cfg_write;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]  cfg_data;
    logic              start;
    logic              busy;
    logic [LM_W-1:0]   landmark_x;
    logic [LM_W-1:0]   landmark_y;
    logic              result_valid;
    logic [CELL_W-1:0] cell_x;
    logic [CELL_W-1:0] cell_y;
    logic              inside_map;
    logic [PROB_W-1:0] probability;
    logic              last_cell;

    // Shadow copies of the registers and the exponential table.
    int                 sh_width;
    int                 sh_height;
    int                 sh_radius;
    int                 sh_sigma;
    longint unsigned    gauss_lut [EXP_DEPTH];
    cell_word_t         pending_cells [$];
    dir_row_t           dir_rows [N_DIR];
    int                 n_errors;
    int                 n_cells;
    int                 n_words;
    int                 idle_pct;

    gaussian_landmark_heatmap u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .start        (start),
        .busy         (busy),
        .landmark_x   (landmark_x),
        .landmark_y   (landmark_y),
        .result_valid (result_valid),
        .cell_x       (cell_x),
        .cell_y       (cell_y),
        .inside_map   (inside_map),
        .probability  (probability),
        .last_cell    (last_cell)
    );

    // Clock of 10 ns period.
    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Builds exp(-j*16/depth) from a five-term series and eight squarings.
    function automatic longint unsigned gauss_entry(int j);
        longint unsigned y;
        longint unsigned y2;
        longint unsigned y3;
        longint unsigned y4;
        longint unsigned v;
        if (j == 0)
        begin
            return 65536;
        end
        y  = (longint'(j) << 36) / (EXP_DEPTH * 256);
        y2 = (y * y) >> 32;
        y3 = (y2 * y) >> 32;
        y4 = (y3 * y) >> 32;
        v  = (64'd1 << 32) - y + y2 / 2 - y3 / 6 + y4 / 24;
        if (v > 64'hFFFF_FFFF)
        begin
            v = 64'hFFFF_FFFF;
        end
        for (int i = 0; i < 8; i++)
        begin
            v = (v * v + 64'h8000_0000) >> 32;
        end
        v = (v + 32768) >> 16;
        return (v > 65536) ? 65536 : v;
    endfunction

    // Works out every cell of the window for one landmark word.
    task automatic render_window(input int lx, input int ly);
        longint unsigned ev [WIN_MAX];
        longint unsigned w;
        longint unsigned h;
        longint unsigned s;
        longint unsigned den;
        longint unsigned sum;
        longint unsigned d2;
        longint unsigned idx;
        longint unsigned p;
        longint          px;
        longint          py;
        longint          cx;
        longint          cy;
        longint          ox;
        longint          oy;
        longint          gx;
        longint          gy;
        int              r;
        int              n;
        int              k;
        cell_word_t      c;
        w   = (sh_width > MAX_MAP_SIZE) ? MAX_MAP_SIZE : sh_width;
        h   = (sh_height > MAX_MAP_SIZE) ? MAX_MAP_SIZE : sh_height;
        r   = sh_radius;
        s   = (sh_sigma == 0) ? 1 : sh_sigma;
        px  = longint'(lx) * longint'(w);
        py  = longint'(ly) * longint'(h);
        cx  = (px + 32768) >>> 16;
        cy  = (py + 32768) >>> 16;
        den = 2 * s * s;
        sum = 0;
        n   = 0;
        for (int dy = -r; dy <= r; dy++)
        begin
            for (int dx = -r; dx <= r; dx++)
            begin
                ox  = (cx + dx) * 65536 - px;
                oy  = (cy + dy) * 65536 - py;
                d2  = longint'(ox * ox) + longint'(oy * oy);
                idx = ((d2 / den) * EXP_DEPTH + (64'd1 << 19)) >> 20;
                ev[n] = (idx >= EXP_DEPTH) ? 0 : gauss_lut[idx];
                sum += ev[n];
                n++;
            end
        end
        k = 0;
        for (int dy = -r; dy <= r; dy++)
        begin
            for (int dx = -r; dx <= r; dx++)
            begin
                gx = cx + dx;
                gy = cy + dy;
                p  = 0;
                if (sum != 0)
                begin
                    p = (ev[k] * 65536 + sum / 2) / sum;
                    if (p > 65536)
                    begin
                        p = 65536;
                    end
                end
                c.cx     = gx[CELL_W-1:0];
                c.cy     = gy[CELL_W-1:0];
                c.in_map = (gx >= 0 && gy >= 0 && gx < longint'(w) && gy < longint'(h));
                c.prob   = p[PROB_W-1:0];
                c.last   = (k == n - 1);
                pending_cells = {pending_cells, c};
                k++;
            end
        end
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch on %s: got %0d, expected %0d (cell %0d)", what, got, want, n_cells);
        n_errors++;
    endtask

    // Checks each emitted cell against the oldest expected cell.
    always @(posedge clk)
    begin
        cell_word_t e;
        if (rst_n && result_valid)
        begin
            if (pending_cells.size() == 0)
            begin
                report_mismatch("unexpected cell", 1, 0);
            end
            else
            begin
                e = pending_cells.pop_front();
                if (cell_x !== e.cx)
                    report_mismatch("cell_x", cell_x, e.cx);
                if (cell_y !== e.cy)
                    report_mismatch("cell_y", cell_y, e.cy);
                if (inside_map !== e.in_map)
                    report_mismatch("inside_map", inside_map, e.in_map);
                if (probability !== e.prob)
                    report_mismatch("probability", probability, e.prob);
                if (last_cell !== e.last)
                    report_mismatch("last_cell", last_cell, e.last);
            end
            n_cells++;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        @(negedge clk);
        cfg_write = 1'b1;
        cfg_index = idx;
        cfg_data  = value[CFG_W-1:0];
        @(negedge clk);
        cfg_write = 1'b0;
        case (idx)
            CFG_MAP_WIDTH:  sh_width  = value & 'h7FF;
            CFG_MAP_HEIGHT: sh_height = value & 'h7FF;
            CFG_ROI_RADIUS: sh_radius = value & 'h3;
            default:        sh_sigma  = value & 'hFFF;
        endcase
    endtask

    // Waits for every expected cell, then for the block to fall quiet.
    task automatic drain_cells();
        @(negedge clk);
        start = 1'b0;
        while (pending_cells.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (DRAIN) @(negedge clk);
    endtask

    task automatic program_all(input int w, input int h, input int r, input int sig);
        write_reg(CFG_MAP_WIDTH, w);
        write_reg(CFG_MAP_HEIGHT, h);
        write_reg(CFG_ROI_RADIUS, r);
        write_reg(CFG_SIGMA, sig);
    endtask

    // Sends one landmark word; start stays high into the next word unless
    // the sender idles in between. Busy is looked at on the falling edge, so
    // the word is taken at exactly the rising edge that follows.
    task automatic send_word(input int lx, input int ly, input bit typed, input cell_word_t want);
        @(negedge clk);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            start = 1'b0;
            @(negedge clk);
        end
        start      = 1'b1;
        landmark_x = lx[LM_W-1:0];
        landmark_y = ly[LM_W-1:0];
        while (busy)
        begin
            @(negedge clk);
        end
        @(posedge clk);
        if (typed)
        begin
            pending_cells = {pending_cells, want};
        end
        else
        begin
            render_window(lx, ly);
        end
        n_words++;
    endtask

    function automatic int pick_size();
        case ($urandom_range(0, 5))
            0:       return 0;
            1:       return 1;
            2:       return 1024;
            3:       return 2047;
            default: return $urandom_range(1, 2047);
        endcase
    endfunction

    function automatic int pick_sigma();
        case ($urandom_range(0, 5))
            0:       return 0;
            1:       return 16;
            2:       return 4095;
            default: return $urandom_range(16, 4095);
        endcase
    endfunction

    function automatic int pick_coord();
        case ($urandom_range(0, 9))
            0:       return 0;
            1:       return 65536;
            2:       return $urandom_range(65537, 131071);
            default: return $urandom_range(0, 65536);
        endcase
    endfunction

    // Ends a run that hangs.
    initial
    begin
        #5ms;
        $display("gaussian_landmark_heatmap regression: fail");
        $finish;
    end

    initial
    begin
        int phase_idle [6];
        cell_word_t blank;
        for (int j = 0; j < EXP_DEPTH; j++)
        begin
            gauss_lut[j] = gauss_entry(j);
        end
        sh_width   = 64;
        sh_height  = 64;
        sh_radius  = 2;
        sh_sigma   = 256;
        n_errors   = 0;
        n_cells    = 0;
        n_words    = 0;
        idle_pct   = 0;
        blank      = '0;
        cfg_write  = 1'b0;
        cfg_index  = CFG_MAP_WIDTH;
        cfg_data   = '0;
        start      = 1'b0;
        landmark_x = '0;
        landmark_y = '0;
        rst_n      = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed table: corners, single-cell windows with known results,
        // off-map cells, zero map size, a window whose sum is zero, the
        // smallest and largest sigma, saturated map sizes, wrapped coordinates.
        dir_rows[0]  = '{64, 64, 0, 256, 0, 0, 1, '{12'd0, 12'd0, 1'b1, PROB_ONE, 1'b1}};
        dir_rows[1]  = '{64, 64, 0, 256, 65536, 65536, 1,
                         '{12'd64, 12'd64, 1'b0, PROB_ONE, 1'b1}};
        dir_rows[2]  = '{0, 0, 0, 256, 40000, 20000, 1, '{12'd0, 12'd0, 1'b0, PROB_ONE, 1'b1}};
        dir_rows[3]  = '{1, 1, 0, 16, 32767, 0, 1, '{12'd0, 12'd0, 1'b1, 17'd0, 1'b1}};
        dir_rows[4]  = '{64, 64, 2, 256, 0, 0, 0, blank};
        dir_rows[5]  = '{64, 64, 3, 256, 65536, 0, 0, blank};
        dir_rows[6]  = '{64, 64, 3, 256, 32768, 32768, 0, blank};
        dir_rows[7]  = '{1024, 1024, 3, 4095, 12345, 54321, 0, blank};
        dir_rows[8]  = '{2047, 2047, 3, 0, 131071, 131071, 0, blank};
        dir_rows[9]  = '{2047, 1, 1, 16, 100000, 1, 0, blank};
        dir_rows[10] = '{0, 0, 3, 300, 65536, 65536, 0, blank};
        dir_rows[11] = '{17, 33, 1, 128, 30001, 49999, 0, blank};
        dir_rows[12] = '{1024, 512, 3, 16, 65535, 1, 0, blank};
        dir_rows[13] = '{64, 64, 2, 256, 131071, 0, 0, blank};
        for (int i = 0; i < N_DIR; i++)
        begin
            drain_cells();
            program_all(dir_rows[i].w, dir_rows[i].h, dir_rows[i].r, dir_rows[i].sig);
            send_word(dir_rows[i].lx, dir_rows[i].ly, dir_rows[i].typed, dir_rows[i].want);
        end

        // Random phases, each with its own register setting and idle rate.
        phase_idle = '{0, 67, 13, 0, 67, 13};
        for (int ph = 0; ph < 6; ph++)
        begin
            drain_cells();
            idle_pct = phase_idle[ph];
            if (ph == 0)
            begin
                program_all(64, 64, 2, 256);
            end
            else
            begin
                program_all(pick_size(), pick_size(), $urandom_range(0, 3), pick_sigma());
            end
            for (int i = 0; i < 82; i++)
            begin
                send_word(pick_coord(), pick_coord(), 1'b0, blank);
            end
        end
        drain_cells();

        $display("sent %0d landmark words, checked %0d window cells", n_words, n_cells);
        $display("covered %0d register settings with sender idling at 0, 13 and 67 percent",
                 N_DIR + 6);
        if (n_errors == 0)
        begin
            $display("gaussian_landmark_heatmap regression: pass");
        end
        else
        begin
            $display("gaussian_landmark_heatmap regression: fail");
        end
        $finish;
    end
endmodule

// File: filelist.f
hw/rtl/glh_pkg.sv
hw/rtl/glh_front.sv
hw/rtl/glh_queue.sv
hw/rtl/glh_div.sv
hw/rtl/glh_back.sv
hw/rtl/gaussian_landmark_heatmap.sv
tb/sv/tb.sv
